// ===== design/cda_pkg.sv =====
// Shared types, constants and helpers for the calendar date advance block.
`default_nettype none
package cda_pkg;

    localparam int unsigned VAL_W   = 16;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned YEAR_W  = 16;
    localparam int unsigned CNT_W   = 17;
    localparam int unsigned YMOD_W  = 9;
    localparam int unsigned MUL_W   = 17;
    localparam int unsigned PROD_W  = 2 * MUL_W;

    localparam logic [YEAR_W-1:0]  YEAR_MAX    = 16'd65535;
    localparam logic [DAY_W-1:0]   DAY_RESET   = 5'd6;
    localparam logic [MONTH_W-1:0] MONTH_RESET = 4'd1;
    localparam logic [YEAR_W-1:0]  YEAR_RESET  = 16'd18;
    localparam logic [YMOD_W-1:0]  YMOD_RESET  = 9'd18;
    localparam logic [DAY_W-1:0]   DAY_FIX     = 5'd16;
    localparam logic [MONTH_W-1:0] MONTH_FIX   = 4'd10;
    localparam logic [MONTH_W-1:0] MONTH_LAST  = 4'd12;
    localparam logic [YMOD_W-1:0]  YMOD_LAST   = 9'd399;

    // Reciprocals: floor(x * RECIP_12 >> 19) == x / 12 for x < 2^17,
    // floor(y * RECIP_400 >> 25) == y / 400 for y < 2^16.
    localparam logic [MUL_W-1:0] RECIP_12    = 17'd43691;
    localparam int unsigned      SHIFT_12    = 19;
    localparam logic [MUL_W-1:0] RECIP_400   = 17'd83887;
    localparam int unsigned      SHIFT_400   = 25;
    localparam int unsigned      Q12_W       = 14;
    localparam int unsigned      Q400_W      = 8;

    typedef enum logic [1:0] {
        MODE_SET    = 2'd0,
        MODE_DAYS   = 2'd1,
        MODE_MONTHS = 2'd2,
        MODE_YEARS  = 2'd3
    } t_mode;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_YMUL = 8'b0000_0010,
        S_YMOD = 8'b0000_0100,
        S_DCHK = 8'b0000_1000,
        S_MMUL = 8'b0001_0000,
        S_MDIV = 8'b0010_0000,
        S_WALK = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        if ((m <= 4'd7 && m[0]) || (m > 4'd7 && !m[0])) begin
            len = 5'd31;
        end else if (m == 4'd2) begin
            len = leap ? 5'd29 : 5'd28;
        end else begin
            len = 5'd30;
        end
        return len;
    endfunction

endpackage
`default_nettype wire

// ===== design/cda_in_if.sv =====
// Command channel: mode and the three value fields.
`default_nettype none
interface cda_in_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    mode;
    logic [cda_pkg::VAL_W-1:0]     day_value;
    logic [cda_pkg::VAL_W-1:0]     month_value;
    logic [cda_pkg::VAL_W-1:0]     year_value;

    modport source (output valid, output mode, output day_value, output month_value,
                    output year_value, input ready);
    modport sink   (input valid, input mode, input day_value, input month_value,
                    input year_value, output ready);
endinterface
`default_nettype wire

// ===== design/cda_out_if.sv =====
// Result channel: the date after each command.
`default_nettype none
interface cda_out_if;
    logic                          valid;
    logic                          ready;
    logic [cda_pkg::DAY_W-1:0]     cur_day;
    logic [cda_pkg::MONTH_W-1:0]   cur_month;
    logic [cda_pkg::YEAR_W-1:0]    cur_year;

    modport source (output valid, output cur_day, output cur_month, output cur_year,
                    input ready);
    modport sink   (input valid, input cur_day, input cur_month, input cur_year,
                    output ready);
endinterface
`default_nettype wire

// ===== design/calendar_date_advance.sv =====
// Date register with set, add-days, add-months and add-years commands.
// States after the accepting edge: add years YMUL, YMOD, DONE; set date YMUL, YMOD,
// DCHK, DONE; add months MMUL, MDIV, YMUL, YMOD, DONE; add days WALK, a walk step per cycle,
// one per month boundary crossed, then DONE. The next command can be taken in the same cycle that the result shows.
// Throughput: one command at a time; a finished beat waits in the output register
// while the next command is taken. The walk loop and the shared multiplier set this.
// Reset: synchronous active low; date returns to day 6, month 1, year 18.
`default_nettype none
module calendar_date_advance (
    input  wire        i_clk,
    input  wire        i_rst_n,
    cda_in_if.sink     i_in,
    cda_out_if.source  o_out
);

    cda_pkg::t_state                 r_state, n_state;
    logic [cda_pkg::DAY_W-1:0]       r_day, n_day;
    logic [cda_pkg::MONTH_W-1:0]     r_month, n_month;
    logic [cda_pkg::YEAR_W-1:0]      r_year, n_year;
    logic [cda_pkg::YMOD_W-1:0]      r_ymod, n_ymod;
    logic                            r_set, n_set;
    logic [cda_pkg::CNT_W-1:0]       r_cnt, n_cnt;
    logic [cda_pkg::PROD_W-1:0]      r_prod, n_prod;
    logic                            r_out_valid, n_out_valid;
    logic [cda_pkg::DAY_W-1:0]       r_out_day, n_out_day;
    logic [cda_pkg::MONTH_W-1:0]     r_out_month, n_out_month;
    logic [cda_pkg::YEAR_W-1:0]      r_out_year, n_out_year;

    logic                            leap;
    logic [cda_pkg::DAY_W-1:0]       mlen;
    logic [cda_pkg::MUL_W-1:0]       mul_a, mul_b;
    logic [cda_pkg::YEAR_W-1:0]      add_b;
    logic [cda_pkg::YEAR_W:0]        add_sum;
    logic [cda_pkg::YEAR_W-1:0]      year_sat;
    logic [cda_pkg::Q12_W-1:0]       q12;
    logic [cda_pkg::CNT_W-1:0]       q12_x12;
    logic [cda_pkg::CNT_W-1:0]       rem12;
    logic [cda_pkg::Q400_W-1:0]      q400;
    logic [cda_pkg::CNT_W-1:0]       q400_x400;
    logic [cda_pkg::CNT_W-1:0]       rem400;
    logic                            in_fire;

    assign in_fire = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == cda_pkg::S_IDLE);

    assign o_out.valid     = r_out_valid;
    assign o_out.cur_day   = r_out_day;
    assign o_out.cur_month = r_out_month;
    assign o_out.cur_year  = r_out_year;

    assign leap = (r_ymod[1:0] == 2'b00)
               && !(r_ymod inside {9'd100, 9'd200, 9'd300});
    assign mlen = cda_pkg::month_len(r_month, leap);

    // shared multiplier: month carry by 1/12, year split by 1/400
    assign mul_a = (r_state == cda_pkg::S_MMUL) ? r_cnt : {1'b0, r_year};
    assign mul_b = (r_state == cda_pkg::S_MMUL) ? cda_pkg::RECIP_12 : cda_pkg::RECIP_400;

    assign q12       = r_prod[cda_pkg::SHIFT_12 +: cda_pkg::Q12_W];
    assign q12_x12   = {q12, 3'b000} + {1'b0, q12, 2'b00};
    assign rem12     = r_cnt - q12_x12;
    assign q400      = r_prod[cda_pkg::SHIFT_400 +: cda_pkg::Q400_W];
    assign q400_x400 = {1'b0, q400, 8'd0} + {2'b00, q400, 7'd0} + {5'd0, q400, 4'd0};
    assign rem400    = {1'b0, r_year} - q400_x400;

    // shared saturating year adder
    always_comb begin
        if (r_state == cda_pkg::S_IDLE) begin
            add_b = i_in.year_value;
        end else if (r_state == cda_pkg::S_MDIV) begin
            add_b = {{(cda_pkg::YEAR_W - cda_pkg::Q12_W){1'b0}}, q12};
        end else begin
            add_b = 16'd1;
        end
    end
    assign add_sum  = {1'b0, r_year} + {1'b0, add_b};
    assign year_sat = add_sum[cda_pkg::YEAR_W] ? cda_pkg::YEAR_MAX
                                               : add_sum[cda_pkg::YEAR_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_day       = r_day;
        n_month     = r_month;
        n_year      = r_year;
        n_ymod      = r_ymod;
        n_set       = r_set;
        n_cnt       = r_cnt;
        n_prod      = r_prod;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_day   = r_out_day;
        n_out_month = r_out_month;
        n_out_year  = r_out_year;

        case (r_state)
            cda_pkg::S_IDLE: begin
                if (in_fire) begin
                    n_set = 1'b0;
                    case (cda_pkg::t_mode'(i_in.mode))
                        cda_pkg::MODE_SET: begin
                            n_year  = i_in.year_value;
                            n_month = (i_in.month_value >= 16'd1 && i_in.month_value <= 16'd12)
                                    ? i_in.month_value[cda_pkg::MONTH_W-1:0]
                                    : cda_pkg::MONTH_FIX;
                            n_cnt   = {1'b0, i_in.day_value};
                            n_set   = 1'b1;
                            n_state = cda_pkg::S_YMUL;
                        end
                        cda_pkg::MODE_DAYS: begin
                            n_cnt   = {12'd0, r_day} + {1'b0, i_in.day_value};
                            n_state = cda_pkg::S_WALK;
                        end
                        cda_pkg::MODE_MONTHS: begin
                            n_cnt   = {13'd0, r_month} - 17'd1 + {1'b0, i_in.month_value};
                            n_state = cda_pkg::S_MMUL;
                        end
                        cda_pkg::MODE_YEARS: begin
                            n_year  = year_sat;
                            n_state = cda_pkg::S_YMUL;
                        end
                        default: begin
                            n_state = cda_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            cda_pkg::S_MMUL: begin
                n_prod  = mul_a * mul_b;
                n_state = cda_pkg::S_MDIV;
            end
            cda_pkg::S_MDIV: begin
                n_month = rem12[cda_pkg::MONTH_W-1:0] + 4'd1;
                n_year  = year_sat;
                n_state = cda_pkg::S_YMUL;
            end
            cda_pkg::S_YMUL: begin
                n_prod  = mul_a * mul_b;
                n_state = cda_pkg::S_YMOD;
            end
            cda_pkg::S_YMOD: begin
                n_ymod  = rem400[cda_pkg::YMOD_W-1:0];
                n_state = r_set ? cda_pkg::S_DCHK : cda_pkg::S_DONE;
            end
            cda_pkg::S_DCHK: begin
                n_day   = (r_cnt != '0 && r_cnt <= {12'd0, mlen})
                        ? r_cnt[cda_pkg::DAY_W-1:0] : cda_pkg::DAY_FIX;
                n_state = cda_pkg::S_DONE;
            end
            cda_pkg::S_WALK: begin
                if (r_cnt > {12'd0, mlen}) begin
                    n_cnt = r_cnt - {12'd0, mlen};
                    if (r_month == cda_pkg::MONTH_LAST) begin
                        n_month = 4'd1;
                        n_year  = year_sat;
                        if (r_year != cda_pkg::YEAR_MAX) begin
                            n_ymod = (r_ymod == cda_pkg::YMOD_LAST) ? '0 : r_ymod + 9'd1;
                        end
                    end else begin
                        n_month = r_month + 4'd1;
                    end
                end else begin
                    n_day   = r_cnt[cda_pkg::DAY_W-1:0];
                    n_state = cda_pkg::S_DONE;
                end
            end
            cda_pkg::S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_day   = r_day;
                    n_out_month = r_month;
                    n_out_year  = r_year;
                    n_state     = cda_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cda_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cda_pkg::S_IDLE;
            r_day       <= cda_pkg::DAY_RESET;
            r_month     <= cda_pkg::MONTH_RESET;
            r_year      <= cda_pkg::YEAR_RESET;
            r_ymod      <= cda_pkg::YMOD_RESET;
            r_set       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_day       <= n_day;
            r_month     <= n_month;
            r_year      <= n_year;
            r_ymod      <= n_ymod;
            r_set       <= n_set;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt       <= n_cnt;
        r_prod      <= n_prod;
        r_out_day   <= n_out_day;
        r_out_month <= n_out_month;
        r_out_year  <= n_out_year;
    end

endmodule
`default_nettype wire

// ===== design/cda_checker.sv =====
// Port-level checks for the calendar date advance block, with its bind.
`default_nettype none
module cda_checker (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    input  wire                              i_in_ready,
    input  wire                              i_out_valid,
    input  wire                              i_out_ready,
    input  wire [cda_pkg::DAY_W-1:0]         i_cur_day,
    input  wire [cda_pkg::MONTH_W-1:0]       i_cur_month,
    input  wire [cda_pkg::YEAR_W-1:0]        i_cur_year
);

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_cur_day)
            && $stable(i_cur_month) && $stable(i_cur_year))
        else $error("stalled result beat changed");

    // drop ready while a command is at work
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("command accepted while busy");

    a_month: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_cur_month >= 4'd1 && i_cur_month <= 4'd12)
        else $error("result month out of range");

    a_day: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_cur_day != 5'd0)
        else $error("result day is zero");

endmodule

bind calendar_date_advance cda_checker u_cda_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_cur_day   (o_out.cur_day),
    .i_cur_month (o_out.cur_month),
    .i_cur_year  (o_out.cur_year)
);
`default_nettype wire

// ===== tb/sv/calendar_date_advance_tb.sv =====
// Self-checking testbench for calendar_date_advance: directed table, random commands, idling.
`timescale 1ns / 100ps
`default_nettype none
module calendar_date_advance_tb;

    typedef struct {
        cda_pkg::t_mode                mode;
        logic [cda_pkg::VAL_W-1:0]     day_value;
        logic [cda_pkg::VAL_W-1:0]     month_value;
        logic [cda_pkg::VAL_W-1:0]     year_value;
    } t_date_cmd;

    typedef struct {
        logic [cda_pkg::DAY_W-1:0]     day;
        logic [cda_pkg::MONTH_W-1:0]   month;
        logic [cda_pkg::YEAR_W-1:0]    year;
    } t_date;

    typedef struct {
        t_date_cmd cmd;
        bit        known;
        t_date     want;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    cda_in_if  cmd_if ();
    cda_out_if date_if ();

    calendar_date_advance i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_if),
        .o_out   (date_if)
    );

    always #6 i_clk = ~i_clk;

    int unsigned cal_day;
    int unsigned cal_month;
    int unsigned cal_year;

    t_date       pending_dates[$];
    t_dir_row    dir_rows[$];
    int unsigned mismatches   = 0;
    int unsigned tx_idle_pct  = 30;
    int unsigned rx_idle_pct  = 70;
    bit          hold_request = 1'b0;

    function automatic bit leap_year(int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
        int unsigned n;
        case (m)
            1, 3, 5, 7, 8, 10, 12: n = 31;
            2:                     n = leap_year(y) ? 29 : 28;
            default:               n = 30;
        endcase
        return n;
    endfunction

    function automatic void bump_years(int unsigned n);
        cal_year = (cal_year + n > cda_pkg::YEAR_MAX) ? cda_pkg::YEAR_MAX : cal_year + n;
    endfunction

    function automatic void bump_months(int unsigned n);
        int unsigned total;
        total = cal_month - 1 + n;
        bump_years(total / 12);
        cal_month = total % 12 + 1;
    endfunction

    function automatic t_date advance_date(t_date_cmd c);
        t_date       d;
        int unsigned walk;
        case (c.mode)
            cda_pkg::MODE_SET: begin
                cal_year  = c.year_value;
                cal_month = (c.month_value >= 1 && c.month_value <= 12) ? c.month_value : 10;
                cal_day   = (c.day_value >= 1 &&
                             c.day_value <= days_in_month(cal_month, cal_year)) ?
                            c.day_value : 16;
            end
            cda_pkg::MODE_DAYS: begin
                walk = cal_day + c.day_value;
                while (walk > days_in_month(cal_month, cal_year)) begin
                    walk -= days_in_month(cal_month, cal_year);
                    bump_months(1);
                end
                cal_day = walk;
            end
            cda_pkg::MODE_MONTHS: bump_months(c.month_value);
            default:              bump_years(c.year_value);
        endcase
        d.day   = cal_day[cda_pkg::DAY_W-1:0];
        d.month = cal_month[cda_pkg::MONTH_W-1:0];
        d.year  = cal_year[cda_pkg::YEAR_W-1:0];
        return d;
    endfunction

    function automatic void add_row(cda_pkg::t_mode m, int unsigned dv, int unsigned mv,
                                    int unsigned yv, bit known, int unsigned d,
                                    int unsigned mo, int unsigned y);
        t_dir_row r;
        r.cmd.mode        = m;
        r.cmd.day_value   = dv[cda_pkg::VAL_W-1:0];
        r.cmd.month_value = mv[cda_pkg::VAL_W-1:0];
        r.cmd.year_value  = yv[cda_pkg::VAL_W-1:0];
        r.known           = known;
        r.want.day        = d[cda_pkg::DAY_W-1:0];
        r.want.month      = mo[cda_pkg::MONTH_W-1:0];
        r.want.year       = y[cda_pkg::YEAR_W-1:0];
        dir_rows.push_back(r);
    endfunction

    function automatic t_date_cmd random_cmd();
        t_date_cmd   c;
        int unsigned r;
        r = $urandom_range(0, 99);
        c.mode        = (r < 25) ? cda_pkg::MODE_SET : (r < 60) ? cda_pkg::MODE_DAYS :
                        (r < 80) ? cda_pkg::MODE_MONTHS : cda_pkg::MODE_YEARS;
        c.day_value   = 16'($urandom);
        c.month_value = 16'($urandom);
        c.year_value  = 16'($urandom);
        r = $urandom_range(0, 99);
        case (c.mode)
            cda_pkg::MODE_SET: begin
                if (r < 85) begin
                    c.day_value   = 16'($urandom_range(0, 32));
                    c.month_value = 16'($urandom_range(0, 13));
                end
                if (r < 60) begin
                    c.year_value = 16'($urandom_range(1580, 2500));
                end else if (r < 70) begin
                    c.year_value = 16'($urandom_range(65500, 65535));
                end
            end
            cda_pkg::MODE_DAYS: begin
                if (r < 80) begin
                    c.day_value = 16'($urandom_range(0, 400));
                end else if (r < 90) begin
                    c.day_value = 16'($urandom_range(0, 3000));
                end
            end
            cda_pkg::MODE_MONTHS: begin
                if (r < 80) begin
                    c.month_value = 16'($urandom_range(0, 40));
                end
            end
            default: begin
                if (r < 80) begin
                    c.year_value = 16'($urandom_range(0, 500));
                end
            end
        endcase
        return c;
    endfunction

    task automatic report(string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic offer(t_date_cmd c, bit known, t_date want);
        t_date expd;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            cmd_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_if.valid       <= 1'b1;
        cmd_if.mode        <= c.mode;
        cmd_if.day_value   <= c.day_value;
        cmd_if.month_value <= c.month_value;
        cmd_if.year_value  <= c.year_value;
        do @(posedge i_clk); while (!cmd_if.ready);
        expd = advance_date(c);
        pending_dates.push_back(known ? want : expd);
    endtask

    task automatic drain();
        cmd_if.valid <= 1'b0;
        while (pending_dates.size() != 0) @(posedge i_clk);
    endtask

    // result side: check each beat, pick ready for the next edge
    initial begin
        t_date       want;
        int unsigned hold_cnt;
        bit          rdy;
        hold_cnt      = 0;
        date_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (date_if.valid && date_if.ready) begin
                if (pending_dates.size() == 0) begin
                    report($sformatf("unexpected beat %0d/%0d/%0d", date_if.cur_day,
                                     date_if.cur_month, date_if.cur_year));
                end else begin
                    want = pending_dates.pop_front();
                    if (date_if.cur_day !== want.day)
                        report($sformatf("day got %0d expected %0d",
                                         date_if.cur_day, want.day));
                    if (date_if.cur_month !== want.month)
                        report($sformatf("month got %0d expected %0d",
                                         date_if.cur_month, want.month));
                    if (date_if.cur_year !== want.year)
                        report($sformatf("year got %0d expected %0d",
                                         date_if.cur_year, want.year));
                end
            end
            if (hold_cnt != 0) begin
                hold_cnt--;
                rdy = 1'b0;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_cnt     = 300;
                rdy          = 1'b0;
            end else begin
                rdy = ($urandom_range(0, 99) >= rx_idle_pct);
            end
            date_if.ready <= rdy;
            @(posedge i_clk);
        end
    end

    initial begin
        #40_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        t_date none;
        none               = '{default: '0};
        i_rst_n            <= 1'b0;
        cmd_if.valid       <= 1'b0;
        cmd_if.mode        <= cda_pkg::MODE_SET;
        cmd_if.day_value   <= '0;
        cmd_if.month_value <= '0;
        cmd_if.year_value  <= '0;
        cal_day            = cda_pkg::DAY_RESET;
        cal_month          = cda_pkg::MONTH_RESET;
        cal_year           = cda_pkg::YEAR_RESET;

        add_row(cda_pkg::MODE_YEARS,      0,     0,     0, 1,  6,  1,    18);
        add_row(cda_pkg::MODE_SET,        0,     0,     0, 1, 16, 10,     0);
        add_row(cda_pkg::MODE_SET,    65535, 65535, 65535, 1, 16, 10, 65535);
        add_row(cda_pkg::MODE_SET,       29,     2,  2000, 1, 29,  2,  2000);
        add_row(cda_pkg::MODE_SET,       29,     2,  1900, 1, 16,  2,  1900);
        add_row(cda_pkg::MODE_SET,       29,     2,  2004, 1, 29,  2,  2004);
        add_row(cda_pkg::MODE_SET,       31,     4,  2001, 1, 16,  4,  2001);
        add_row(cda_pkg::MODE_SET,       12,    13,  2023, 1, 12, 10,  2023);
        add_row(cda_pkg::MODE_SET,       31,     1,  2001, 1, 31,  1,  2001);
        add_row(cda_pkg::MODE_MONTHS,     0,     1,     0, 1, 31,  2,  2001);
        add_row(cda_pkg::MODE_DAYS,       0,     0,     0, 1,  3,  3,  2001);
        add_row(cda_pkg::MODE_SET,       31,    12,   100, 1, 31, 12,   100);
        add_row(cda_pkg::MODE_DAYS,       1,     0,     0, 1,  1,  1,   101);
        add_row(cda_pkg::MODE_MONTHS,     0,    11,     0, 1,  1, 12,   101);
        add_row(cda_pkg::MODE_MONTHS,     0,    12,     0, 1,  1, 12,   102);
        add_row(cda_pkg::MODE_MONTHS,     0, 65535,     0, 0,  0,  0,     0);
        add_row(cda_pkg::MODE_DAYS,   65535,     0,     0, 0,  0,  0,     0);
        add_row(cda_pkg::MODE_YEARS,      0,     0, 65535, 0,  0,  0,     0);
        add_row(cda_pkg::MODE_DAYS,   65535,     0,     0, 0,  0,  0,     0);
        add_row(cda_pkg::MODE_SET,       28,     2, 65535, 1, 28,  2, 65535);
        add_row(cda_pkg::MODE_MONTHS,     0,    12,     0, 1, 28,  2, 65535);
        add_row(cda_pkg::MODE_YEARS,      0,     0,     1, 1, 28,  2, 65535);
        add_row(cda_pkg::MODE_SET,        1,     1,     0, 1,  1,  1,     0);
        add_row(cda_pkg::MODE_DAYS,      59,     0,     0, 0,  0,  0,     0);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) offer(dir_rows[k].cmd, dir_rows[k].known, dir_rows[k].want);
        drain();

        repeat (85) offer(random_cmd(), 1'b0, none);
        drain();

        tx_idle_pct = 70;
        rx_idle_pct = 30;
        repeat (85) offer(random_cmd(), 1'b0, none);
        drain();

        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        hold_request = 1'b1;
        repeat (85) offer(random_cmd(), 1'b0, none);
        drain();

        repeat (100) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire
